// ===== design/ptfv_pkg.sv =====
// Shared types and constants of the partition table fit and victim core.
package ptfv_pkg;

  localparam int unsigned START_W = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned OIDX_W  = 6;

  typedef enum logic [2:0] {
    REQ_FIT     = 3'd0,
    REQ_VICTIM  = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_LOOKUP  = 3'd5,
    REQ_NEXT    = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    CFG_FIT_MODE     = 1'b0,
    CFG_REPLACE_MODE = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SH_RD,
    ST_SH_WR,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               free;
    logic [STAMP_W-1:0] created;
    logic [STAMP_W-1:0] accessed;
  } entry_t;

endpackage

// ===== design/partition_table_fit_and_victim_core.sv =====
// Partition table with fit search, victim choice and ordered insert and remove.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i, in_stall_o | req_type_i .. entry_accessed_i
//  out     | source    | out_valid_o, out_stall_i | status_o .. time_stamp_o
//  cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// A request first scans the table: the scan reads one entry a cycle from the table memory,
// which has one read and one write port. Victim and replace then write the chosen entry; insert
// moves the entries above the insert point up one place, remove moves those above the entry down.
// Reset clears the entry count, stamp counter and modes; the table contents need no clearing.
// The next request is taken while a finished result waits in the output register.
module partition_table_fit_and_victim_core
  import ptfv_pkg::*;
#(
  parameter int unsigned MAX_PARTITIONS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [SIZE_W-1:0]  request_size_i,
  input  logic [START_W-1:0] key_start_i,
  input  logic [START_W-1:0] entry_start_i,
  input  logic [SIZE_W-1:0]  entry_size_i,
  input  logic               entry_free_i,
  input  logic [STAMP_W-1:0] entry_created_i,
  input  logic [STAMP_W-1:0] entry_accessed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [OIDX_W-1:0]  result_index_o,
  output logic [START_W-1:0] result_start_o,
  output logic [SIZE_W-1:0]  result_size_o,
  output logic               result_free_o,
  output logic [STAMP_W-1:0] result_created_o,
  output logic [STAMP_W-1:0] result_accessed_o,
  output logic [STAMP_W-1:0] time_stamp_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic               cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PARTITIONS);
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1);

  state_e state_q, state_d;

  entry_t mem [MAX_PARTITIONS];
  entry_t rd_data_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic fit_mode_q, replace_mode_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [STAMP_W-1:0] tctr_q, tctr_d;

  req_e             req_q, req_d;
  logic [SIZE_W-1:0]  want_q, want_d;
  logic [START_W-1:0] key_q, key_d;
  entry_t             new_q, new_d;

  logic [CNT_W-1:0] ptr_q, ptr_d, pos_q, pos_d;
  logic             dvld_q, dvld_d;
  logic [IDX_W-1:0] didx_q, didx_d;
  logic             found_q, found_d;
  entry_t           best_q, best_d;
  logic [IDX_W-1:0] bidx_q, bidx_d;
  logic             shup_q, shup_d;
  entry_t           wr_q, wr_d;

  logic [1:0]         rstat_q, rstat_d;
  logic [OIDX_W-1:0]  ridx_q, ridx_d;
  entry_t             rent_q, rent_d;
  logic [STAMP_W-1:0] rts_q, rts_d;

  logic               ovld_q, ovld_d;
  logic [1:0]         ostat_q, ostat_d;
  logic [OIDX_W-1:0]  oidx_q, oidx_d;
  entry_t             oent_q, oent_d;
  logic [STAMP_W-1:0] ots_q, ots_d;

  logic accept, out_free, take;
  logic [STAMP_W-1:0] cand_key, best_key;
  logic [CNT_W-1:0]   ins_pos;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !ovld_q || !out_stall_i;
  assign cand_key = replace_mode_q ? rd_data_q.accessed : rd_data_q.created;
  assign best_key = replace_mode_q ? best_q.accessed : best_q.created;
  assign ins_pos  = (count_q == '0) ? '0 : CNT_W'(bidx_q) + CNT_W'(1);

  always_comb begin
    take = 1'b0;
    case (req_q)
      REQ_FIT: take = rd_data_q.free && (rd_data_q.size >= want_q) &&
                      (!found_q || (fit_mode_q && rd_data_q.size < best_q.size));
      REQ_VICTIM: take = !rd_data_q.free && (!found_q || cand_key < best_key);
      REQ_INSERT, REQ_REPLACE, REQ_REMOVE, REQ_LOOKUP:
        take = !found_q && (rd_data_q.start == key_q);
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (ptr_q >= count_q && !dvld_q) state_d = ST_DECIDE;
      ST_DECIDE: begin
        state_d = ST_DONE;
        case (req_q)
          REQ_VICTIM, REQ_REPLACE: if (found_q) state_d = ST_WRITE;
          REQ_REMOVE: if (found_q) state_d = ST_SH_RD;
          REQ_INSERT: begin
            if ((count_q == '0 || found_q) && count_q < CNT_W'(MAX_PARTITIONS)) begin
              state_d = ST_SH_RD;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SH_RD: begin
        if (shup_q) begin
          state_d = (ptr_q > pos_q) ? ST_SH_WR : ST_WRITE;
        end else begin
          state_d = (ptr_q + CNT_W'(1) < count_q) ? ST_SH_WR : ST_DONE;
        end
      end
      ST_SH_WR:  state_d = ST_SH_RD;
      ST_WRITE:  state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d = req_q; want_d = want_q; key_d = key_q; new_d = new_q;
    ptr_d = ptr_q; pos_d = pos_q; dvld_d = 1'b0; didx_d = didx_q;
    found_d = found_q; best_d = best_q; bidx_d = bidx_q; shup_d = shup_q; wr_d = wr_q;
    rstat_d = rstat_q; ridx_d = ridx_q; rent_d = rent_q; rts_d = rts_q;
    count_d = count_q; tctr_d = tctr_q;
    ovld_d = ovld_q && out_stall_i;
    ostat_d = ostat_q; oidx_d = oidx_q; oent_d = oent_q; ots_d = ots_q;
    mem_we = 1'b0; mem_waddr = ptr_q[IDX_W-1:0]; mem_wdata = rd_data_q;
    mem_raddr = ptr_q[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d  = req_e'(req_type_i);
          want_d = request_size_i;
          key_d  = key_start_i;
          new_d  = '{start: entry_start_i, size: entry_size_i, free: entry_free_i,
                     created: entry_created_i, accessed: entry_accessed_i};
          ptr_d = '0; found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (ptr_q < count_q) begin
          ptr_d = ptr_q + CNT_W'(1); dvld_d = 1'b1; didx_d = ptr_q[IDX_W-1:0];
        end
        if (dvld_q && take) begin
          found_d = 1'b1; best_d = rd_data_q; bidx_d = didx_q;
        end
      end
      ST_DECIDE: begin
        rstat_d = STAT_MISS; ridx_d = '0; rent_d = '0; rts_d = '0;
        case (req_q)
          REQ_FIT, REQ_LOOKUP: begin
            if (found_q) begin
              rstat_d = STAT_OK; ridx_d = OIDX_W'(bidx_q); rent_d = best_q;
            end
          end
          REQ_VICTIM: begin
            if (found_q) begin
              rstat_d = STAT_OK; ridx_d = OIDX_W'(bidx_q);
              rent_d = best_q; rent_d.free = 1'b1;
              wr_d = best_q; wr_d.free = 1'b1; pos_d = CNT_W'(bidx_q);
            end
          end
          REQ_REPLACE: begin
            if (found_q) begin
              rstat_d = STAT_OK; ridx_d = OIDX_W'(bidx_q); rent_d = new_q;
              wr_d = new_q; pos_d = CNT_W'(bidx_q);
            end
          end
          REQ_REMOVE: begin
            if (found_q) begin
              rstat_d = STAT_OK; ridx_d = OIDX_W'(bidx_q); rent_d = best_q;
              ptr_d = CNT_W'(bidx_q); shup_d = 1'b0;
            end
          end
          REQ_INSERT: begin
            if (count_q == '0 || found_q) begin
              if (count_q >= CNT_W'(MAX_PARTITIONS)) begin
                rstat_d = STAT_FULL;
              end else begin
                rstat_d = STAT_OK; ridx_d = OIDX_W'(ins_pos); rent_d = new_q;
                wr_d = new_q; pos_d = ins_pos; ptr_d = count_q; shup_d = 1'b1;
              end
            end
          end
          REQ_NEXT: begin
            tctr_d = tctr_q + STAMP_W'(1);
            rstat_d = STAT_OK; rts_d = tctr_q + STAMP_W'(1);
          end
          default: rstat_d = STAT_MISS;
        endcase
      end
      ST_SH_RD: begin
        if (shup_q) begin
          mem_raddr = IDX_W'(ptr_q - CNT_W'(1));
        end else begin
          mem_raddr = IDX_W'(ptr_q + CNT_W'(1));
          if (!(ptr_q + CNT_W'(1) < count_q)) count_d = count_q - CNT_W'(1);
        end
      end
      ST_SH_WR: begin
        mem_we = 1'b1; mem_waddr = ptr_q[IDX_W-1:0]; mem_wdata = rd_data_q;
        ptr_d = shup_q ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
      end
      ST_WRITE: begin
        mem_we = 1'b1; mem_waddr = pos_q[IDX_W-1:0]; mem_wdata = wr_q;
        if (req_q == REQ_INSERT) count_d = count_q + CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_d = 1'b1; ostat_d = rstat_q; oidx_d = ridx_q; oent_d = rent_q; ots_d = rts_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fit_mode_q <= 1'b0;
      replace_mode_q <= 1'b0;
      count_q <= '0;
      tctr_q <= '0;
      dvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      tctr_q <= tctr_d;
      dvld_q <= dvld_d;
      ovld_q <= ovld_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_FIT_MODE:     fit_mode_q <= cfg_wdata_i;
          CFG_REPLACE_MODE: replace_mode_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; want_q <= want_d; key_q <= key_d; new_q <= new_d;
    ptr_q <= ptr_d; pos_q <= pos_d; didx_q <= didx_d; found_q <= found_d;
    best_q <= best_d; bidx_q <= bidx_d; shup_q <= shup_d; wr_q <= wr_d;
    rstat_q <= rstat_d; ridx_q <= ridx_d; rent_q <= rent_d; rts_q <= rts_d;
    ostat_q <= ostat_d; oidx_q <= oidx_d; oent_q <= oent_d; ots_q <= ots_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = ovld_q;
  assign status_o          = ostat_q;
  assign result_index_o    = oidx_q;
  assign result_start_o    = oent_q.start;
  assign result_size_o     = oent_q.size;
  assign result_free_o     = oent_q.free;
  assign result_created_o  = oent_q.created;
  assign result_accessed_o = oent_q.accessed;
  assign time_stamp_o      = ots_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PARTITIONS))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(count_q))
    else $error("entry count changed while idle");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN))
    else $error("accepted beat did not start a scan");

endmodule
